@@ src/dmx_pkg.sv @@
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types and codes of the distributed mutex node: transaction payloads,
// command and phase codes, and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dmx_pkg;

    // Sizing
    localparam int NODES         = 16;
    localparam int NODE_BITS     = 4;
    localparam int COUNT_BITS    = 5;
    localparam int STAMP_BITS    = 48;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // Input commands
    localparam logic [1:0] CMD_REQ = 2'd0;
    localparam logic [1:0] CMD_ASK = 2'd1;
    localparam logic [1:0] CMD_OK  = 2'd2;
    localparam logic [1:0] CMD_REL = 2'd3;

    // Outgoing message kinds
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_ASK  = 2'd1;
    localparam logic [1:0] K_OK   = 2'd2;

    // Node phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_NODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 2'd1;

    // Input transaction
    typedef struct packed {
        logic [1:0]            cmd;
        logic [NODE_BITS-1:0]  peer;
        logic [STAMP_BITS-1:0] stamp;
    } t_dmx_in;

    // Result transaction
    typedef struct packed {
        logic [1:0]           msg_kind;
        logic [NODE_BITS-1:0] dest;
        logic                 holding;
        logic                 error;
        logic                 last;
    } t_dmx_out;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic exec;     // apply the latched item
        logic emit;     // send the next message of a fan-out
    } t_dmx_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic multi;      // latched item fans out to several messages
        logic scan_last;  // next message sent is the final one
    } t_dmx_status;

endpackage

@@ src/dmx_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmx_ctrl
// Sequencer of the mutex node: takes one item, applies it, then walks any
// fan-out of messages one per cycle while the output register has room.
// ----------------------------------------------------------------------------
module dmx_ctrl
    import dmx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_dmx_status i_status,
    output t_dmx_cmd    o_cmd,
    output logic        o_in_stall
);

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.emit    = 1'b0;
        case (r_state)
            ST_READY: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.multi ? ST_SCAN : ST_READY;
                end
            end
            ST_SCAN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ST_READY;
                    end
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_READY);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/dmx_dp.sv @@
// ----------------------------------------------------------------------------
// dmx_dp
// Datapath of the mutex node: configuration, phase, ok count, deferred marks,
// own request stamp, the fan-out mask and the registered result.
// ----------------------------------------------------------------------------
module dmx_dp
    import dmx_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dmx_cmd                 i_cmd,
    output t_dmx_status              o_status,
    input  t_dmx_in                  i_in_data,
    input  logic                     i_cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_out_valid,
    output t_dmx_out                 o_out_data,
    input  logic                     i_out_stall
);

    logic [NODE_BITS-1:0]  r_own,       n_own;
    logic [COUNT_BITS-1:0] r_count,     n_count;
    logic [1:0]            r_phase,     n_phase;
    logic [COUNT_BITS-1:0] r_okc,       n_okc;
    logic [NODES-1:0]      r_defer,     n_defer;
    logic [STAMP_BITS-1:0] r_stamp,     n_stamp;
    logic [NODES-1:0]      r_scan,      n_scan;
    logic [1:0]            r_scan_kind, n_scan_kind;
    logic                  r_out_valid, n_out_valid;
    t_dmx_out              r_out,       n_out;
    t_dmx_in               r_item,      n_item;

    logic [COUNT_BITS-1:0] eff_count;
    logic [COUNT_BITS-1:0] needed;
    logic [COUNT_BITS-1:0] okc_inc;
    logic [NODES-1:0]      elig;
    logic [NODES-1:0]      rel_mask;
    logic [NODES-1:0]      scan_low;
    logic [NODES-1:0]      scan_rest;
    logic [NODE_BITS-1:0]  scan_idx;
    logic                  peer_ok;
    logic                  earlier;
    logic                  out_free;

    // Participant count clamped to 1..NODES, and the oks needed
    always_comb begin
        if (r_count == '0) begin
            eff_count = COUNT_BITS'(1);
        end else if (r_count > COUNT_BITS'(NODES)) begin
            eff_count = COUNT_BITS'(NODES);
        end else begin
            eff_count = r_count;
        end
        needed = ({1'b0, r_own} < eff_count) ? eff_count - COUNT_BITS'(1) : eff_count;
    end

    // Every other participant
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            elig[i] = (COUNT_BITS'(i) < eff_count) && (NODE_BITS'(i) != r_own);
        end
    end

    assign rel_mask = r_defer & elig;
    assign peer_ok  = (r_item.peer != r_own) && ({1'b0, r_item.peer} < eff_count);
    // Peer's request wins: earlier stamp, or lower id on a tie
    assign earlier  = (r_item.stamp < r_stamp) ||
                      ((r_item.stamp == r_stamp) && (r_item.peer < r_own));
    assign okc_inc  = (r_okc != '1) ? r_okc + COUNT_BITS'(1) : r_okc;

    // Lowest pending destination of the fan-out
    assign scan_low  = r_scan & (~r_scan + NODES'(1));
    assign scan_rest = r_scan & (r_scan - NODES'(1));
    always_comb begin
        scan_idx = '0;
        for (int i = 0; i < NODES; i++) begin
            if (scan_low[i]) begin
                scan_idx = scan_idx | NODE_BITS'(i);
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller
    always_comb begin
        o_status.out_free  = out_free;
        o_status.multi     = ((r_item.cmd == CMD_REQ) && (r_phase == PH_IDLE) &&
                              (needed != '0)) ||
                             ((r_item.cmd == CMD_REL) && (r_phase == PH_HOLD) &&
                              (rel_mask != '0));
        o_status.scan_last = (scan_rest == '0);
    end

    // Next-state logic
    always_comb begin
        n_own       = r_own;
        n_count     = r_count;
        n_phase     = r_phase;
        n_okc       = r_okc;
        n_defer     = r_defer;
        n_stamp     = r_stamp;
        n_scan      = r_scan;
        n_scan_kind = r_scan_kind;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        // Configuration writes
        if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_OWN_NODE:   n_own   = i_cfg_data[NODE_BITS-1:0];
                CFG_NODE_COUNT: n_count = i_cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end

        if (i_cmd.capture) begin
            n_item = i_in_data;
        end

        // Apply the latched item
        if (i_cmd.exec) begin
            n_out.msg_kind = K_NONE;
            n_out.dest     = '0;
            n_out.holding  = (r_phase == PH_HOLD);
            n_out.error    = 1'b0;
            n_out.last     = 1'b1;
            n_out_valid    = 1'b1;
            case (r_item.cmd)
                CMD_REQ: begin
                    if (r_phase != PH_IDLE) begin
                        n_out.error = 1'b1;
                    end else begin
                        n_stamp = r_item.stamp;
                        n_okc   = '0;
                        if (needed == '0) begin
                            n_phase       = PH_HOLD;
                            n_out.holding = 1'b1;
                        end else begin
                            n_phase     = PH_WAIT;
                            n_scan      = elig;
                            n_scan_kind = K_ASK;
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    end
                end
                CMD_ASK: begin
                    if (!peer_ok) begin
                        n_out.error = 1'b1;
                    end else if ((r_phase == PH_IDLE) || ((r_phase == PH_WAIT) && earlier)) begin
                        n_out.msg_kind = K_OK;
                        n_out.dest     = r_item.peer;
                    end else begin
                        n_defer[r_item.peer] = 1'b1;
                    end
                end
                CMD_OK: begin
                    if ((r_phase != PH_WAIT) || !peer_ok) begin
                        n_out.error = 1'b1;
                    end else begin
                        n_okc = okc_inc;
                        if (okc_inc >= needed) begin
                            n_phase       = PH_HOLD;
                            n_out.holding = 1'b1;
                        end
                    end
                end
                CMD_REL: begin
                    if (r_phase != PH_HOLD) begin
                        n_out.error = 1'b1;
                    end else begin
                        n_phase       = PH_IDLE;
                        n_okc         = '0;
                        n_defer       = '0;
                        n_out.holding = 1'b0;
                        if (rel_mask != '0) begin
                            n_scan      = rel_mask;
                            n_scan_kind = K_OK;
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    end
                end
                default: ;
            endcase
        end

        // One fan-out message per cycle while the output register has room
        if (i_cmd.emit) begin
            n_out.msg_kind = r_scan_kind;
            n_out.dest     = scan_idx;
            n_out.holding  = 1'b0;
            n_out.error    = 1'b0;
            n_out.last     = (scan_rest == '0);
            n_out_valid    = 1'b1;
            n_scan         = scan_rest;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own       <= '0;
            r_count     <= COUNT_BITS'(NODES);
            r_phase     <= PH_IDLE;
            r_okc       <= '0;
            r_defer     <= '0;
            r_stamp     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_own       <= n_own;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_okc       <= n_okc;
            r_defer     <= n_defer;
            r_stamp     <= n_stamp;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_scan_kind <= n_scan_kind;
        r_item      <= n_item;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idle_no_oks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_okc == '0))
        else $error("ok count nonzero while idle");

    a_idle_no_defer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !i_cmd.exec) |-> (r_defer == '0))
        else $error("deferred marks left while idle");

    a_scan_not_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan != '0) |-> (r_phase != PH_HOLD))
        else $error("fan-out pending while holding");

    a_holding_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.holding) |-> (r_phase == PH_HOLD))
        else $error("holding flag without hold phase");

    a_emit_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && r_out.msg_kind != K_NONE))
        else $error("fan-out result carries no message");
`endif

endmodule

@@ src/distributed_mutex_node.sv @@
// One node of timestamp-based distributed mutual exclusion. Each input item is
// taken into a holding register, applied once the output register has room,
// and its results leave through a single output register, so a single-result
// item (ask, ok, error, request when alone, release with nothing deferred)
// holds the input stalled until its result is registered. A request fans out
// one ask per other participant (up to 15) and a release one ok per deferred
// peer, in rising id order, one message per cycle from a scan over the node
// mask while the output is not stalled. Configuration writes are always taken
// (register 0 own node id, register 1 node count); no clearing pass after reset.
// ----------------------------------------------------------------------------
// distributed_mutex_node
// Top level: controller and datapath of one mutual exclusion node.
// ----------------------------------------------------------------------------
module distributed_mutex_node
    import dmx_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_dmx_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_dmx_out                 o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dmx_cmd    cmd;
    t_dmx_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    dmx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // State and result path
    dmx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
